// File: rtl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Types and constants shared by the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

    localparam int KEY_W    = 63;
    localparam int HND_W    = 12;
    localparam int SLOT_W   = 12;
    localparam int CNT_W    = 13;
    localparam int CAPACITY = 4096;
    localparam int HANDLES  = 4096;

    // request codes
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELMIN = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_UPDATE = 2'd3
    } req_t;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    // one heap slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [HND_W-1:0] hnd;
    } entry_t;

endpackage

// File: rtl/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Binary min-heap of (key, handle) entries with a handle-to-slot map.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// word appears for one cycle with done high and cannot be held off. The heap
// walks one level at a time through the heap memory; a delete walks to the
// root, then sifts down. After reset the block clears the presence memory,
// holding busy high meanwhile.
module indexed_min_heap_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic [imhq_pkg::HND_W-1:0]   handle,
    input  logic [imhq_pkg::KEY_W-1:0]   key,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [imhq_pkg::HND_W-1:0]   out_handle,
    output logic [imhq_pkg::KEY_W-1:0]   out_key,
    output logic [imhq_pkg::SLOT_W-1:0]  out_slot,
    output logic [imhq_pkg::CNT_W-1:0]   occupancy
);
    import imhq_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_CHECK    = 14'b00000000000100,
        S_TGT      = 14'b00000000001000,
        S_UP       = 14'b00000000010000,
        S_UP_CMP   = 14'b00000000100000,
        S_SHIFT    = 14'b00000001000000,
        S_SHIFT_WR = 14'b00000010000000,
        S_REMOVE   = 14'b00000100000000,
        S_REM_LD   = 14'b00001000000000,
        S_DOWN     = 14'b00010000000000,
        S_DOWN_CMP = 14'b00100000000000,
        S_FINAL    = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    // memories
    entry_t            heap_mem    [CAPACITY];
    logic [SLOT_W-1:0] map_mem     [HANDLES];
    logic              present_mem [HANDLES];

    state_t            state_reg, state_next;
    logic [HND_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    entry_t            mov_reg, mov_next;
    req_t              req_reg, req_next;
    logic [HND_W-1:0]  hnd_reg, hnd_next;
    logic [2:0]        status_reg, status_next;
    logic [HND_W-1:0]  oh_reg, oh_next;
    logic [KEY_W-1:0]  ok_reg, ok_next;
    logic [SLOT_W-1:0] os_reg, os_next;

    // memory ports
    logic [SLOT_W-1:0] ra_addr, rb_addr;
    entry_t            ra_data, rb_data;
    logic              hw_en;
    logic [SLOT_W-1:0] hw_addr;
    entry_t            hw_data;
    logic              mw_en;
    logic [HND_W-1:0]  mw_addr;
    logic [SLOT_W-1:0] mw_data;
    logic              pw_en;
    logic [HND_W-1:0]  pw_addr;
    logic              pw_data;
    logic              pres_rd;
    logic [SLOT_W-1:0] slot_rd;

    // index arithmetic
    logic [SLOT_W-1:0] parent;
    logic [CNT_W-1:0]  left;
    logic [CNT_W:0]    right;
    logic              pick_left;
    entry_t            child;
    logic [SLOT_W-1:0] child_pos;

    assign parent    = (pos_reg - SLOT_W'(1)) >> 1;
    assign left      = {pos_reg, 1'b1};
    assign right     = {1'b0, left} + (CNT_W+1)'(1);
    assign pick_left = (right >= {1'b0, count_reg}) || (ra_data.key < rb_data.key);
    assign child     = pick_left ? ra_data : rb_data;
    assign child_pos = pick_left ? left[SLOT_W-1:0] : right[SLOT_W-1:0];

    // heap memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heap_mem[hw_addr] <= hw_data;
        end
        ra_data <= heap_mem[ra_addr];
        rb_data <= heap_mem[rb_addr];
    end

    // handle map and presence memories
    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            map_mem[mw_addr] <= mw_data;
        end
        if (pw_en)
        begin
            present_mem[pw_addr] <= pw_data;
        end
        slot_rd <= map_mem[handle];
        pres_rd <= present_mem[handle];
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        mov_next    = mov_reg;
        req_next    = req_reg;
        hnd_next    = hnd_reg;
        status_next = status_reg;
        oh_next     = oh_reg;
        ok_next     = ok_reg;
        os_next     = os_reg;
        ra_addr     = '0;
        rb_addr     = '0;
        hw_en       = 1'b0;
        hw_addr     = pos_reg;
        hw_data     = mov_reg;
        mw_en       = 1'b0;
        mw_addr     = mov_reg.hnd;
        mw_data     = pos_reg;
        pw_en       = 1'b0;
        pw_addr     = hnd_reg;
        pw_data     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                pw_en    = 1'b1;
                pw_addr  = clr_reg;
                clr_next = clr_reg + HND_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_t'(req_type);
                    hnd_next   = handle;
                    mov_next   = '{key: key, hnd: handle};
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                status_next = ST_OK;
                oh_next     = hnd_reg;
                ok_next     = '0;
                os_next     = '0;
                unique case (req_reg)
                    REQ_INSERT:
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (pres_rd)
                        begin
                            status_next = ST_PRESENT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pw_en      = 1'b1;
                            pw_data    = 1'b1;
                            pos_next   = count_reg[SLOT_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                            ok_next    = mov_reg.key;
                            state_next = S_UP;
                        end
                    end
                    REQ_DELMIN:
                    begin
                        ra_addr = '0;
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_TGT;
                        end
                    end
                    REQ_DELETE:
                    begin
                        ra_addr = slot_rd;
                        if (!pres_rd)
                        begin
                            status_next = ST_ABSENT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pw_en      = 1'b1;
                            pos_next   = slot_rd;
                            state_next = S_TGT;
                        end
                    end
                    default:
                    begin
                        if (!pres_rd)
                        begin
                            status_next = ST_ABSENT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pos_next   = slot_rd;
                            ok_next    = mov_reg.key;
                            state_next = S_UP;
                        end
                    end
                endcase
            end
            S_TGT:
            begin
                // capture removed entry; root removal drops its presence
                ok_next = ra_data.key;
                if (req_reg == REQ_DELMIN)
                begin
                    oh_next    = ra_data.hnd;
                    pw_en      = 1'b1;
                    pw_addr    = ra_data.hnd;
                    state_next = S_REMOVE;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_UP:
            begin
                ra_addr = parent;
                if (pos_reg == '0)
                begin
                    state_next = (req_reg == REQ_UPDATE) ? S_DOWN : S_FINAL;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (ra_data.key > mov_reg.key)
                begin
                    hw_en      = 1'b1;
                    hw_data    = ra_data;
                    mw_en      = 1'b1;
                    mw_addr    = ra_data.hnd;
                    pos_next   = parent;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = (req_reg == REQ_UPDATE) ? S_DOWN : S_FINAL;
                end
            end
            S_SHIFT:
            begin
                ra_addr = parent;
                state_next = (pos_reg == '0) ? S_REMOVE : S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // move the ancestor down one level
                hw_en      = 1'b1;
                hw_data    = ra_data;
                mw_en      = 1'b1;
                mw_addr    = ra_data.hnd;
                pos_next   = parent;
                state_next = S_SHIFT;
            end
            S_REMOVE:
            begin
                ra_addr    = SLOT_W'(count_reg - CNT_W'(1));
                count_next = count_reg - CNT_W'(1);
                pos_next   = '0;
                state_next = (count_reg == CNT_W'(1)) ? S_DONE : S_REM_LD;
            end
            S_REM_LD:
            begin
                mov_next   = ra_data;
                state_next = S_DOWN;
            end
            S_DOWN:
            begin
                ra_addr = left[SLOT_W-1:0];
                rb_addr = right[SLOT_W-1:0];
                state_next = (left >= count_reg) ? S_FINAL : S_DOWN_CMP;
            end
            S_DOWN_CMP:
            begin
                if (mov_reg.key > child.key)
                begin
                    hw_en      = 1'b1;
                    hw_data    = child;
                    mw_en      = 1'b1;
                    mw_addr    = child.hnd;
                    pos_next   = child_pos;
                    state_next = S_DOWN;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                hw_en = 1'b1;
                mw_en = 1'b1;
                if (req_reg == REQ_INSERT || req_reg == REQ_UPDATE)
                begin
                    os_next = pos_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        mov_reg    <= mov_next;
        req_reg    <= req_next;
        hnd_reg    <= hnd_next;
        status_reg <= status_next;
        oh_reg     <= oh_next;
        ok_reg     <= ok_next;
        os_reg     <= os_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign status     = status_reg;
    assign out_handle = oh_reg;
    assign out_key    = ok_reg;
    assign out_slot   = os_reg;
    assign occupancy  = count_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request taken without busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after result word");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> $stable(count_reg)) else $error("count moved while idle");

endmodule

// File: test/tb_indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_queue
// Self-checking bench for the indexed min-heap queue: a driver feeds request
// words from a pending queue, a mirror of the heap predicts every result word
// and a monitor compares each done word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import imhq_pkg::*;

    typedef struct {
        req_t             req;
        logic [HND_W-1:0] hnd;
        logic [KEY_W-1:0] k;
        bit               drain;   // wait for every result before presenting
    } request_word_t;

    typedef struct {
        logic [2:0]        st;
        logic [HND_W-1:0]  hnd;
        logic [KEY_W-1:0]  k;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  occ;
    } result_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          req_type = 2'd0;
    logic [HND_W-1:0]    handle = '0;
    logic [KEY_W-1:0]    key = '0;
    logic                busy;
    logic                done;
    logic [2:0]          status;
    logic [HND_W-1:0]    out_handle;
    logic [KEY_W-1:0]    out_key;
    logic [SLOT_W-1:0]   out_slot;
    logic [CNT_W-1:0]    occupancy;

    request_word_t pending_words[$];
    request_word_t cur_word;
    result_word_t  expected_words[$];
    int            fail_count = 0;
    int            accepted_count = 0;

    // mirror of the heap
    logic [KEY_W-1:0]  heap_key[CAPACITY];
    logic [HND_W-1:0]  heap_hnd[CAPACITY];
    logic [SLOT_W-1:0] slot_of[HANDLES];
    bit                is_present[HANDLES];
    int                heap_count;

    indexed_min_heap_queue i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .handle(handle), .key(key), .done(done),
        .status(status), .out_handle(out_handle), .out_key(out_key),
        .out_slot(out_slot), .occupancy(occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void swap_entries(int a, int b);
        logic [KEY_W-1:0] tk;
        logic [HND_W-1:0] th;
        tk = heap_key[a];
        th = heap_hnd[a];
        heap_key[a] = heap_key[b];
        heap_hnd[a] = heap_hnd[b];
        heap_key[b] = tk;
        heap_hnd[b] = th;
        slot_of[heap_hnd[a]] = SLOT_W'(a);
        slot_of[heap_hnd[b]] = SLOT_W'(b);
    endfunction

    function automatic int walk_up(int c);
        int p;
        while (c > 0)
        begin
            p = (c - 1) / 2;
            if (heap_key[p] > heap_key[c])
            begin
                swap_entries(c, p);
                c = p;
            end
            else
                break;
        end
        return c;
    endfunction

    function automatic int walk_down(int p);
        int l;
        int c;
        while (2 * p + 1 < heap_count)
        begin
            l = 2 * p + 1;
            if (l + 1 >= heap_count || heap_key[l] < heap_key[l + 1])
                c = l;
            else
                c = l + 1;
            if (heap_key[p] > heap_key[c])
            begin
                swap_entries(p, c);
                p = c;
            end
            else
                break;
        end
        return p;
    endfunction

    function automatic void pop_root(ref result_word_t r);
        int last;
        last = heap_count - 1;
        r.hnd = heap_hnd[0];
        r.k = heap_key[0];
        is_present[heap_hnd[0]] = 1'b0;
        if (last > 0)
        begin
            heap_key[0] = heap_key[last];
            heap_hnd[0] = heap_hnd[last];
            slot_of[heap_hnd[0]] = '0;
        end
        heap_count = last;
        void'(walk_down(0));
    endfunction

    // compute the result word of one request and advance the mirror
    function automatic result_word_t heap_outcome(request_word_t w);
        result_word_t r;
        int c;
        r.st = ST_OK;
        r.hnd = w.hnd;
        r.k = '0;
        r.slot = '0;
        case (w.req)
            REQ_INSERT:
            begin
                if (heap_count >= CAPACITY)
                    r.st = ST_FULL;
                else if (is_present[w.hnd])
                    r.st = ST_PRESENT;
                else
                begin
                    heap_key[heap_count] = w.k;
                    heap_hnd[heap_count] = w.hnd;
                    slot_of[w.hnd] = SLOT_W'(heap_count);
                    is_present[w.hnd] = 1'b1;
                    heap_count++;
                    r.slot = SLOT_W'(walk_up(heap_count - 1));
                    r.k = w.k;
                end
            end
            REQ_DELMIN:
            begin
                if (heap_count == 0)
                    r.st = ST_EMPTY;
                else
                    pop_root(r);
            end
            REQ_DELETE:
            begin
                if (!is_present[w.hnd])
                    r.st = ST_ABSENT;
                else
                begin
                    c = slot_of[w.hnd];
                    if (c >= heap_count)
                        c = heap_count - 1;
                    while (c > 0)
                    begin
                        swap_entries(c, (c - 1) / 2);
                        c = (c - 1) / 2;
                    end
                    pop_root(r);
                    r.hnd = w.hnd;
                end
            end
            default:
            begin
                if (!is_present[w.hnd])
                    r.st = ST_ABSENT;
                else
                begin
                    c = slot_of[w.hnd];
                    if (c >= heap_count)
                        c = heap_count - 1;
                    heap_key[c] = w.k;
                    c = walk_up(c);
                    r.slot = SLOT_W'(walk_down(c));
                    r.k = w.k;
                end
            end
        endcase
        r.occ = CNT_W'(heap_count);
        return r;
    endfunction

    // drive request words; predict each one as it is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_words.push_back(heap_outcome(cur_word));
                accepted_count++;
            end
            if (!start || !busy)
            begin
                if (pending_words.size() > 0
                    && !(pending_words[0].drain && expected_words.size() > 0)
                    && !((accepted_count < 1000 || accepted_count > 1500)
                         && $urandom_range(0, 99) < 11))
                begin
                    cur_word = pending_words.pop_front();
                    start <= 1'b1;
                    req_type <= cur_word.req;
                    handle <= cur_word.hnd;
                    key <= cur_word.k;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        result_word_t e;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word, status %0d handle %0d", $realtime,
                         status, out_handle);
                fail_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (status !== e.st)
                begin
                    $display("%0t: status exp %0d got %0d", $realtime, e.st, status);
                    fail_count++;
                end
                if (out_handle !== e.hnd)
                begin
                    $display("%0t: out_handle exp %0d got %0d", $realtime, e.hnd, out_handle);
                    fail_count++;
                end
                if (out_key !== e.k)
                begin
                    $display("%0t: out_key exp %h got %h", $realtime, e.k, out_key);
                    fail_count++;
                end
                if (out_slot !== e.slot)
                begin
                    $display("%0t: out_slot exp %0d got %0d", $realtime, e.slot, out_slot);
                    fail_count++;
                end
                if (occupancy !== e.occ)
                begin
                    $display("%0t: occupancy exp %0d got %0d", $realtime, e.occ, occupancy);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return {KEY_W{1'b1}};
            1:       return '0;
            2, 3:    return KEY_W'($urandom_range(0, 15));
            default: return raw[KEY_W-1:0];
        endcase
    endfunction

    function automatic void queue_word(req_t r, int h, logic [KEY_W-1:0] k, bit d = 1'b0);
        request_word_t w;
        w.req = r;
        w.hnd = HND_W'(h);
        w.k = k;
        w.drain = d;
        pending_words.push_back(w);
    endfunction

    initial
    begin
        int h;
        for (int i = 0; i < HANDLES; i++)
            is_present[i] = 1'b0;
        heap_count = 0;

        // directed: extremes, duplicates, absent handles, equal keys, empty heap
        queue_word(REQ_DELMIN, 0, '0);
        queue_word(REQ_DELETE, 5, '0);
        queue_word(REQ_UPDATE, 4095, {KEY_W{1'b1}});
        queue_word(REQ_INSERT, 4095, {KEY_W{1'b1}});
        queue_word(REQ_INSERT, 0, '0);
        queue_word(REQ_INSERT, 4095, 63'd7);
        queue_word(REQ_INSERT, 1, 63'd5);
        queue_word(REQ_INSERT, 2, 63'd5);
        queue_word(REQ_INSERT, 3, 63'd5);
        queue_word(REQ_UPDATE, 0, {KEY_W{1'b1}});
        queue_word(REQ_UPDATE, 4095, '0);
        queue_word(REQ_UPDATE, 2, 63'd5);
        queue_word(REQ_DELETE, 3, '0);
        queue_word(REQ_DELETE, 3, '0);
        queue_word(REQ_DELMIN, 0, '0);
        queue_word(REQ_DELETE, 0, '0);
        queue_word(REQ_DELMIN, 0, '0);
        queue_word(REQ_DELMIN, 0, '0);
        queue_word(REQ_DELMIN, 0, '0, 1'b1);

        // random traffic over a small handle pool, some over the full range
        for (int i = 0; i < 1880; i++)
        begin
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 47);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_word(REQ_INSERT, h, pick_key(), i == 950);
                4, 5:       queue_word(REQ_DELMIN, h, pick_key(), i == 950);
                6, 7:       queue_word(REQ_DELETE, h, pick_key(), i == 950);
                default:    queue_word(REQ_UPDATE, h, pick_key(), i == 950);
            endcase
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_words.size() == 0 && !start && expected_words.size() == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // end the run if the block stops answering
    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end

endmodule
